// ----- design/scrolling_tilemap_layer_defines.svh -----
// ----------------------------------------------------------------------------
// scrolling_tilemap_layer_defines.svh
// Assertion macros for the tile layer controller.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TILEMAP_LAYER_DEFINES_SVH
`define SCROLLING_TILEMAP_LAYER_DEFINES_SVH

// same-cycle implication
`define STL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tile layer check failed");

// next-cycle implication
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tile layer check failed");

`endif

// ----- design/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Shared codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stl_pkg;

   typedef enum logic [1:0] {
      FUNC_MAP_WR  = 2'd0,
      FUNC_ATTR_WR = 2'd1,
      FUNC_FRAME   = 2'd2,
      FUNC_STEP    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_TILE_W    = 3'd0,
      CSR_TILE_H    = 3'd1,
      CSR_MAP_W     = 3'd2,
      CSR_MAP_H     = 3'd3,
      CSR_EDGE_MODE = 3'd4,
      CSR_ID_MASK   = 3'd5,
      CSR_FLAG_MASK = 3'd6,
      CSR_TILE_LIM  = 3'd7
   } csr_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_IMAGE = 2'd2
   } kind_type;

   localparam logic [7:0]  CODE_IMAGE  = 8'd1;
   localparam logic [7:0]  CODE_FILL_A = 8'd2;
   localparam logic [7:0]  CODE_FILL_B = 8'd5;
   localparam logic [12:0] EXTRA_TILES = 13'd2;

   // divider jobs, in issue order
   typedef enum logic [2:0] {
      OP_MODX, OP_DIVX, OP_SWX, OP_MODY, OP_DIVY, OP_SHY, OP_MX, OP_MY
   } op_type;

   typedef struct packed {
      logic   load_in;
      logic   wr_map;
      logic   wr_attr;
      logic   frame_clear;
      logic   frame_set;
      logic   div_start;
      logic   latch;
      op_type op;
      logic   map_rd;
      logic   attr_rd;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic frame_active;
      logic size_zero;
      logic div_done;
   } status_type;

endpackage

// ----- design/stl_divider.sv -----
// ----------------------------------------------------------------------------
// stl_divider
// 16-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stl_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient,
   output logic [15:0] remainder
);
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;
   logic [16:0] trial;

   assign shifted = {rem_ff[15:0], quo_ff[15]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (!trial[16]) begin
            rem_in = trial;
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in  = cnt_ff - 5'd1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) dvs_ff <= divisor;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[15:0];
endmodule

// ----- design/stl_datapath.sv -----
// ----------------------------------------------------------------------------
// stl_datapath
// Config registers, map and attribute stores, camera setup and tile output.
// ----------------------------------------------------------------------------
module stl_datapath #(
   parameter int MAP_DEPTH  = 65536,
   parameter int TILE_TYPES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  stl_pkg::cmd_type    cmd,
   output stl_pkg::status_type status,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic [15:0]         req_address,
   input  logic [7:0]          req_data,
   input  logic [7:0]          req_image_sel,
   input  logic                req_image_present,
   input  logic signed [15:0]  req_cam_x,
   input  logic signed [15:0]  req_cam_y,
   input  logic [11:0]         req_screen_width,
   input  logic [11:0]         req_screen_height,
   output logic                rsp_strobe,
   output logic signed [13:0]  rsp_pos_x,
   output logic signed [13:0]  rsp_pos_y,
   output logic                rsp_underlay_fill,
   output logic [1:0]          rsp_draw_kind,
   output logic [7:0]          rsp_image_number,
   output logic                rsp_last
);
   import stl_pkg::*;

   localparam int MAP_AW = $clog2(MAP_DEPTH);
   localparam int TT_AW  = $clog2(TILE_TYPES);

   logic [7:0] tile_w_ff, tile_h_ff, map_w_ff, map_h_ff;
   logic [1:0] edge_ff;
   logic [7:0] id_mask_ff, flag_mask_ff, tile_lim_ff;

   logic [7:0]  map_mem [MAP_DEPTH];
   logic [16:0] attr_mem [TILE_TYPES];

   logic signed [15:0] cam_x_ff, cam_y_ff;
   logic [11:0] sw_ff, sh_ff;
   logic [15:0] cx_ff, cy_ff;
   logic [7:0]  start_col_ff, start_row_ff, shift_x_ff, shift_y_ff;
   logic [12:0] cols_ff, rows_ff, col_ff, row_ff;
   logic        active_ff;
   logic [12:0] mx_ff, my_ff;
   logic [7:0]  map_q_ff;
   logic [16:0] attr_q_ff;
   logic        in_map_ff, id_ok_ff;

   // camera placement
   logic [15:0] layer_x, layer_y;
   logic [16:0] diff_x, diff_y;
   logic [15:0] max_x, max_y, cl_x, cl_y, abs_x, abs_y, wr_x, wr_y;
   assign layer_x = 16'(map_w_ff) * 16'(tile_w_ff);
   assign layer_y = 16'(map_h_ff) * 16'(tile_h_ff);
   assign diff_x  = {1'b0, layer_x} - 17'(sw_ff);
   assign diff_y  = {1'b0, layer_y} - 17'(sh_ff);
   assign max_x   = diff_x[16] ? 16'd0 : diff_x[15:0];
   assign max_y   = diff_y[16] ? 16'd0 : diff_y[15:0];
   assign cl_x = cam_x_ff[15] ? 16'd0 :
                 ((16'(cam_x_ff) > max_x) ? max_x : 16'(cam_x_ff));
   assign cl_y = cam_y_ff[15] ? 16'd0 :
                 ((16'(cam_y_ff) > max_y) ? max_y : 16'(cam_y_ff));
   assign abs_x = cam_x_ff[15] ? (~16'(cam_x_ff) + 16'd1) : 16'(cam_x_ff);
   assign abs_y = cam_y_ff[15] ? (~16'(cam_y_ff) + 16'd1) : 16'(cam_y_ff);

   // divider
   logic [15:0] dvd, dvs, quo, rem;
   logic        div_done;
   assign wr_x = (cam_x_ff[15] && rem != 16'd0) ? (layer_x - rem) : rem;
   assign wr_y = (cam_y_ff[15] && rem != 16'd0) ? (layer_y - rem) : rem;

   logic [12:0] mx_raw, my_raw;
   assign mx_raw = 13'(start_col_ff) + col_ff;
   assign my_raw = 13'(start_row_ff) + row_ff;

   always_comb begin
      unique case (cmd.op)
         OP_MODX: begin dvd = abs_x;             dvs = layer_x;          end
         OP_DIVX: begin dvd = cx_ff;             dvs = 16'(tile_w_ff);   end
         OP_SWX:  begin dvd = 16'(sw_ff);        dvs = 16'(tile_w_ff);   end
         OP_MODY: begin dvd = abs_y;             dvs = layer_y;          end
         OP_DIVY: begin dvd = cy_ff;             dvs = 16'(tile_h_ff);   end
         OP_SHY:  begin dvd = 16'(sh_ff);        dvs = 16'(tile_h_ff);   end
         OP_MX:   begin dvd = 16'(mx_raw);       dvs = 16'(map_w_ff);    end
         OP_MY:   begin dvd = 16'(my_raw);       dvs = 16'(map_h_ff);    end
         default: begin dvd = '0;                dvs = 16'd1;            end
      endcase
   end

   stl_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // map lookup
   logic [15:0] lin, lin_mod, wa_mod;
   logic        in_map;
   assign lin     = 16'(my_ff[7:0]) * 16'(map_w_ff) + 16'(mx_ff[7:0]);
   assign lin_mod = 16'(lin % MAP_DEPTH);
   assign wa_mod  = 16'(req_address % MAP_DEPTH);
   assign in_map  = (!edge_ff[0] || mx_ff < 13'(map_w_ff)) &&
                    (!edge_ff[1] || my_ff < 13'(map_h_ff));

   logic [7:0] tile_id;
   logic       id_ok;
   assign tile_id = map_q_ff & id_mask_ff;
   assign id_ok   = in_map_ff && (tile_id < tile_lim_ff) &&
                    (9'(tile_id) < 9'(TILE_TYPES));

   // output formation
   logic [20:0] prod_x, prod_y;
   logic [7:0]  code;
   logic [1:0]  kind;
   logic [12:0] col_nx, row_nx;
   assign prod_x = 21'(col_ff) * 21'(tile_w_ff);
   assign prod_y = 21'(row_ff) * 21'(tile_h_ff);
   assign code   = attr_q_ff[7:0];
   assign col_nx = col_ff + 13'd1;
   assign row_nx = row_ff + 13'd1;

   always_comb begin
      kind = KIND_NONE;
      if (id_ok_ff) begin
         if (code == CODE_FILL_A || code == CODE_FILL_B) kind = KIND_FILL;
         else if (code == CODE_IMAGE && attr_q_ff[16]) kind = KIND_IMAGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_w_ff    <= 8'd8;
         tile_h_ff    <= 8'd8;
         map_w_ff     <= 8'd32;
         map_h_ff     <= 8'd32;
         edge_ff      <= 2'd0;
         id_mask_ff   <= 8'd255;
         flag_mask_ff <= 8'd0;
         tile_lim_ff  <= 8'd0;
         active_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         start_col_ff <= '0;
         start_row_ff <= '0;
         shift_x_ff   <= '0;
         shift_y_ff   <= '0;
         cols_ff      <= '0;
         rows_ff      <= '0;
         rsp_strobe   <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit;
         if (csr_we) begin
            unique case (csr_type'(csr_index))
               CSR_TILE_W:    tile_w_ff    <= csr_wdata;
               CSR_TILE_H:    tile_h_ff    <= csr_wdata;
               CSR_MAP_W:     map_w_ff     <= csr_wdata;
               CSR_MAP_H:     map_h_ff     <= csr_wdata;
               CSR_EDGE_MODE: edge_ff      <= csr_wdata[1:0];
               CSR_ID_MASK:   id_mask_ff   <= csr_wdata;
               CSR_FLAG_MASK: flag_mask_ff <= csr_wdata;
               CSR_TILE_LIM:  tile_lim_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.frame_clear) active_ff <= 1'b0;
         if (cmd.latch) begin
            unique case (cmd.op)
               OP_DIVX: begin start_col_ff <= quo[7:0]; shift_x_ff <= rem[7:0]; end
               OP_SWX:  cols_ff <= quo[12:0] + EXTRA_TILES;
               OP_DIVY: begin start_row_ff <= quo[7:0]; shift_y_ff <= rem[7:0]; end
               OP_SHY:  rows_ff <= quo[12:0] + EXTRA_TILES;
               default: ;
            endcase
         end
         if (cmd.frame_set) begin
            col_ff    <= '0;
            row_ff    <= '0;
            active_ff <= 1'b1;
         end
         if (cmd.emit) begin
            if (col_nx >= cols_ff) begin
               col_ff <= '0;
               if (row_nx >= rows_ff) begin
                  row_ff    <= '0;
                  active_ff <= 1'b0;
               end else begin
                  row_ff <= row_nx;
               end
            end else begin
               col_ff <= col_nx;
            end
         end
      end

      if (cmd.load_in) begin
         cam_x_ff <= req_cam_x;
         cam_y_ff <= req_cam_y;
         sw_ff    <= req_screen_width;
         sh_ff    <= req_screen_height;
      end
      if (cmd.latch) begin
         unique case (cmd.op)
            OP_MODX: cx_ff <= edge_ff[0] ? cl_x : wr_x;
            OP_MODY: cy_ff <= edge_ff[1] ? cl_y : wr_y;
            OP_MX:   mx_ff <= edge_ff[0] ? mx_raw : rem[12:0];
            OP_MY:   my_ff <= edge_ff[1] ? my_raw : rem[12:0];
            default: ;
         endcase
      end
      if (cmd.wr_map) map_mem[wa_mod[MAP_AW-1:0]] <= req_data;
      if (cmd.wr_attr && 17'(req_address) < 17'(TILE_TYPES)) begin
         attr_mem[req_address[TT_AW-1:0]] <=
            {req_image_present, req_image_sel, req_data};
      end
      if (cmd.map_rd) begin
         map_q_ff  <= map_mem[lin_mod[MAP_AW-1:0]];
         in_map_ff <= in_map;
      end
      if (cmd.attr_rd) begin
         attr_q_ff <= attr_mem[tile_id[TT_AW-1:0]];
         id_ok_ff  <= id_ok;
      end
      if (cmd.emit) begin
         rsp_pos_x         <= prod_x[13:0] - 14'(shift_x_ff);
         rsp_pos_y         <= prod_y[13:0] - 14'(shift_y_ff);
         rsp_underlay_fill <= id_ok_ff && ((map_q_ff & flag_mask_ff) != 8'd0);
         rsp_draw_kind     <= kind;
         rsp_image_number  <= (kind == KIND_IMAGE) ? attr_q_ff[15:8] : 8'd0;
         rsp_last          <= (col_nx >= cols_ff) && (row_nx >= rows_ff);
      end
   end

   assign status.frame_active = active_ff;
   assign status.size_zero    = (tile_w_ff == 8'd0) || (tile_h_ff == 8'd0) ||
                                (map_w_ff == 8'd0) || (map_h_ff == 8'd0);
   assign status.div_done     = div_done;
endmodule

// ----- design/stl_controller.sv -----
// ----------------------------------------------------------------------------
// stl_controller
// Sequencer for frame setup divides and the per-tile lookup.
// ----------------------------------------------------------------------------
`include "scrolling_tilemap_layer_defines.svh"

module stl_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_func,
   output logic                busy,
   output stl_pkg::cmd_type    cmd,
   input  stl_pkg::status_type status
);
   import stl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MAP, S_ATTR, S_OUT
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      accept;

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.op   = op_ff;
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_in = 1'b1;
               unique case (func_type'(req_func))
                  FUNC_MAP_WR:  cmd.wr_map  = 1'b1;
                  FUNC_ATTR_WR: cmd.wr_attr = 1'b1;
                  FUNC_FRAME: begin
                     if (status.size_zero) cmd.frame_clear = 1'b1;
                     else begin
                        op_in    = OP_MODX;
                        state_in = S_DIV_GO;
                     end
                  end
                  FUNC_STEP: begin
                     if (status.frame_active && !status.size_zero) begin
                        op_in    = OP_MX;
                        state_in = S_DIV_GO;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.latch = 1'b1;
               unique case (op_ff)
                  OP_SHY: begin cmd.frame_set = 1'b1; state_in = S_IDLE; end
                  OP_MY:  state_in = S_MAP;
                  default: begin
                     op_in    = op_type'(op_ff + 3'd1);
                     state_in = S_DIV_GO;
                  end
               endcase
            end
         end
         S_MAP:  begin cmd.map_rd  = 1'b1; state_in = S_ATTR; end
         S_ATTR: begin cmd.attr_rd = 1'b1; state_in = S_OUT;  end
         S_OUT:  begin cmd.emit    = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_MODX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `STL_ASSERT_NEXT(a_out_returns, clock, reset, state_ff == S_OUT, state_ff == S_IDLE)
   `STL_ASSERT_NOW(a_done_waiting, clock, reset, status.div_done, state_ff == S_DIV_WAIT)
   `STL_ASSERT_NEXT(a_div_not_instant, clock, reset, cmd.div_start, !status.div_done)
   `STL_ASSERT_NOW(a_emit_frame, clock, reset, cmd.emit, status.frame_active)
endmodule

// ----- design/scrolling_tilemap_layer.sv -----
// ----------------------------------------------------------------------------
// scrolling_tilemap_layer
// Tile background layer engine: map and attribute stores, camera scroll
// setup and per-tile draw commands in raster order.
// ----------------------------------------------------------------------------
// Usage:
//  - A command transaction is taken when start is high and busy is low.
//    req_func selects map write, attribute write, frame start or next tile.
//  - Map and attribute writes are done in the accepting idle state; busy stays low.
//  - A frame start runs six passes of the shared 16-bit serial divider
//    in sequence (camera wrap, start tile/shift and tile count per
//    axis), with busy high throughout. A frame start with any size
//    register at zero just ends the frame, and busy stays low.
//  - A next-tile command runs two divider passes (map column and row
//    wrap), then a map read and an attribute read; rsp_strobe rises
//    and busy drops at the same edge. A next-tile with no frame open
//    gives no result.
//  - Each result is marked by rsp_strobe, high for a single cycle;
//    the receiver cannot stall, so nothing is ever held back.
//  - The csr_ port writes one register per cycle at csr_we; the user must
//    write only while idle, as the block itself does not enforce it.
//  - Synchronous reset restores register defaults and closes any frame;
//    the stores keep their contents and are undefined until written.
// ----------------------------------------------------------------------------
module scrolling_tilemap_layer #(
   parameter int MAP_DEPTH  = 65536,
   parameter int TILE_TYPES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_address,
   input  logic [7:0]         req_data,
   input  logic [7:0]         req_image_sel,
   input  logic               req_image_present,
   input  logic signed [15:0] req_cam_x,
   input  logic signed [15:0] req_cam_y,
   input  logic [11:0]        req_screen_width,
   input  logic [11:0]        req_screen_height,
   output logic               rsp_strobe,
   output logic signed [13:0] rsp_pos_x,
   output logic signed [13:0] rsp_pos_y,
   output logic               rsp_underlay_fill,
   output logic [1:0]         rsp_draw_kind,
   output logic [7:0]         rsp_image_number,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import stl_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   stl_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   // datapath holds config, stores, frame state and the result register
   stl_datapath #(
      .MAP_DEPTH  (MAP_DEPTH),
      .TILE_TYPES (TILE_TYPES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_address       (req_address),
      .req_data          (req_data),
      .req_image_sel     (req_image_sel),
      .req_image_present (req_image_present),
      .req_cam_x         (req_cam_x),
      .req_cam_y         (req_cam_y),
      .req_screen_width  (req_screen_width),
      .req_screen_height (req_screen_height),
      .rsp_strobe        (rsp_strobe),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_underlay_fill (rsp_underlay_fill),
      .rsp_draw_kind     (rsp_draw_kind),
      .rsp_image_number  (rsp_image_number),
      .rsp_last          (rsp_last)
   );
endmodule
